[hdl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_LEN_DEF = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 8'd0,
    REG_PATTERN_LENGTH     = 8'd1,
    REG_REPLACEMENT_BYTES  = 8'd2,
    REG_REPLACEMENT_LENGTH = 8'd3
  } cfg_reg_t;

  // control flags that travel with a burst of result bytes
  typedef struct packed {
    logic last;    // burst closes the stream
    logic marker;  // burst is a bare end marker
  } burst_ctl_t;

endpackage

[hdl/sfr_in_if.sv]
// ----------------------------------------------------------------------------
// sfr_in_if
// Source byte channel: one request carries one byte and its end flag.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[hdl/sfr_out_if.sv]
// ----------------------------------------------------------------------------
// sfr_out_if
// Result byte channel: byte, byte-present flag and end flag.
// ----------------------------------------------------------------------------
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

[hdl/sfr_cfg_if.sv]
// ----------------------------------------------------------------------------
// sfr_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sfr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::CFG_IDX_W-1:0]  index;
  logic [sfr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/sfr_win.sv]
// ----------------------------------------------------------------------------
// sfr_win
// Pending window and match logic: updates the window for one source byte and
// builds the burst of result bytes that the byte causes.
// ----------------------------------------------------------------------------
module sfr_win #(
  parameter int MAX_LEN = sfr_pkg::MAX_LEN_DEF,
  parameter int CW      = $clog2(MAX_LEN + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   in_byte,
  input  logic                         in_last,
  input  logic                         clear,
  input  logic [63:0]                  pattern_bytes,
  input  logic [sfr_pkg::LEN_W-1:0]    pattern_length,
  input  logic [63:0]                  replacement_bytes,
  input  logic [sfr_pkg::LEN_W-1:0]    replacement_length,
  output logic [7:0]                   burst_bytes [MAX_LEN],
  output logic [CW-1:0]                burst_count,
  output sfr_pkg::burst_ctl_t          burst_ctl
);
  import sfr_pkg::*;

  logic [7:0]    window [MAX_LEN];
  logic [7:0]    window_next [MAX_LEN];
  logic [CW-1:0] pending;
  logic [CW-1:0] pending_next;

  logic [7:0]       wn [MAX_LEN];
  logic [LEN_W-1:0] plen_c;
  logic [LEN_W-1:0] rlen_c;
  logic [CW-1:0]    plen;
  logic [CW-1:0]    rlen;
  logic [CW-1:0]    pc;
  logic [CW-1:0]    pc1;
  logic [CW-1:0]    n;
  logic             complete;
  logic             hit;
  logic             match;

  always_comb begin
    plen_c = pattern_length;
    if (plen_c == '0) plen_c = LEN_W'(1);
    if (plen_c > LEN_W'(MAX_LEN)) plen_c = LEN_W'(MAX_LEN);
    plen = CW'(plen_c);
    rlen_c = replacement_length;
    if (rlen_c > LEN_W'(MAX_LEN)) rlen_c = LEN_W'(MAX_LEN);
    rlen = CW'(rlen_c);
  end

  always_comb begin
    pc  = (pending >= plen) ? '0 : pending;
    pc1 = pc + CW'(1);
    for (int i = 0; i < MAX_LEN; i++) begin
      wn[i] = (CW'(i) == pc) ? in_byte : window[i];
    end
    complete = (pc1 == plen);
    hit = 1'b1;
    for (int i = 0; i < MAX_LEN; i++) begin
      if (CW'(i) < plen && wn[i] != pattern_bytes[8*i +: 8]) hit = 1'b0;
    end
    match = complete && hit;

    for (int i = 0; i < MAX_LEN; i++) begin
      burst_bytes[i] = match ? replacement_bytes[8*i +: 8] : wn[i];
    end
    if (match) begin
      n = rlen;
    end else if (in_last) begin
      n = pc1;
    end else begin
      n = complete ? CW'(1) : '0;
    end
    burst_ctl.last   = in_last;
    burst_ctl.marker = in_last && (n == '0);
    burst_count      = burst_ctl.marker ? CW'(1) : n;

    // mismatch on a full window drops the oldest byte
    for (int i = 0; i < MAX_LEN - 1; i++) begin
      window_next[i] = (complete && !match) ? wn[i+1] : wn[i];
    end
    window_next[MAX_LEN-1] = wn[MAX_LEN-1];
    if (in_last || match) begin
      pending_next = '0;
    end else if (complete) begin
      pending_next = pc;
    end else begin
      pending_next = pc1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pending <= '0;
    end else if (accept) begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

[hdl/sfr_emit.sv]
// ----------------------------------------------------------------------------
// sfr_emit
// Result register: holds one burst and sends its bytes one per request.
// ----------------------------------------------------------------------------
module sfr_emit #(
  parameter int MAX_LEN = sfr_pkg::MAX_LEN_DEF,
  parameter int CW      = $clog2(MAX_LEN + 1),
  parameter int IW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [7:0]          burst_bytes [MAX_LEN],
  input  logic [CW-1:0]       burst_count,
  input  sfr_pkg::burst_ctl_t burst_ctl,
  output logic                take,
  sfr_out_if.source           dst
);
  import sfr_pkg::*;

  logic [7:0]    bytes [MAX_LEN];
  logic [CW-1:0] remain;
  logic [IW-1:0] idx;
  burst_ctl_t    ctl;
  logic          pop;

  assign pop          = dst.valid && dst.ready;
  assign take         = (remain == '0) || (remain == CW'(1) && dst.ready);
  assign dst.valid    = (remain != '0);
  assign dst.out_byte = ctl.marker ? 8'd0 : bytes[idx];
  assign dst.out_valid = !ctl.marker;
  assign dst.out_last = ctl.last && (remain == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      idx    <= '0;
    end else if (load && burst_count != '0) begin
      remain <= burst_count;
      idx    <= '0;
    end else if (pop) begin
      remain <= remain - CW'(1);
      idx    <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && burst_count != '0) begin
      bytes <= burst_bytes;
      ctl   <= burst_ctl;
    end
  end

endmodule

[hdl/stream_find_and_replace_top.sv]
// ----------------------------------------------------------------------------
// stream_find_and_replace_top
// Streaming find-and-replace over a byte stream.
// ----------------------------------------------------------------------------
// Channels: src takes one source byte per request with in_last on the final
// byte; dst gives result bytes (out_valid low only on a bare end marker,
// out_last on the final result); cfg writes pattern_bytes (0),
// pattern_length (1), replacement_bytes (2), replacement_length (3), and
// ignores other indexes. cfg is always ready; write it only while idle.
// Writing pattern_length drops any pending window bytes.
// The first result of a byte shows on dst the cycle after the byte
// is taken. A byte with no result does not hold src.
// Throughput: src takes a byte every cycle while each byte causes at most
// one result and dst is ready. A byte that causes more than one result
// (replacement or end flush) holds src low until the last of them is taken
// from the single result register, which drains one byte per cycle while dst
// is ready. src is also held while dst stalls with any result left.
// Reset (rst, synchronous): registers return to pattern 0 of length 1,
// empty replacement, empty window, and dst drops its valid.
// ----------------------------------------------------------------------------
module stream_find_and_replace_top #(
  parameter int MAX_LEN = sfr_pkg::MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst,
  sfr_in_if.sink   src,
  sfr_out_if.source dst,
  sfr_cfg_if.sink  cfg
);
  import sfr_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);

  logic [63:0]      pattern_bytes;
  logic [LEN_W-1:0] pattern_length;
  logic [63:0]      replacement_bytes;
  logic [LEN_W-1:0] replacement_length;

  logic          accept;
  logic          take;
  logic          clear;
  logic [7:0]    burst_bytes [MAX_LEN];
  logic [CW-1:0] burst_count;
  burst_ctl_t    burst_ctl;

  assign cfg.ready = 1'b1;
  assign src.ready = take;
  assign accept    = src.valid && take;
  assign clear     = cfg.valid && cfg.index == REG_PATTERN_LENGTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg.data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg.data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg.data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  sfr_win #(.MAX_LEN(MAX_LEN), .CW(CW)) u_win (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .in_byte            (src.in_byte),
    .in_last            (src.in_last),
    .clear              (clear),
    .pattern_bytes      (pattern_bytes),
    .pattern_length     (pattern_length),
    .replacement_bytes  (replacement_bytes),
    .replacement_length (replacement_length),
    .burst_bytes        (burst_bytes),
    .burst_count        (burst_count),
    .burst_ctl          (burst_ctl)
  );

  sfr_emit #(.MAX_LEN(MAX_LEN), .CW(CW)) u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .burst_bytes (burst_bytes),
    .burst_count (burst_count),
    .burst_ctl   (burst_ctl),
    .take        (take),
    .dst         (dst)
  );

  a_marker_is_end: assert property (@(posedge clk) disable iff (rst)
    dst.valid && !dst.out_valid |-> dst.out_last)
    else $error("bare end marker without out_last");

  a_stall_blocks_src: assert property (@(posedge clk) disable iff (rst)
    dst.valid && !dst.ready |-> !src.ready)
    else $error("source taken while result register is stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !dst.valid)
    else $error("result pending after reset");

  a_burst_fits: assert property (@(posedge clk) disable iff (rst)
    accept |-> burst_count <= CW'(MAX_LEN))
    else $error("burst longer than result register");

endmodule
